// File: src/polyphase_interpolation_fir_macros.svh
// Assertion macros used by the checker of the polyphase interpolator
`ifndef POLYPHASE_INTERPOLATION_FIR_MACROS_SVH
`define POLYPHASE_INTERPOLATION_FIR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PIF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PIF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pif_pkg.sv
// Types and constants shared by the polyphase interpolator modules
package pif_pkg;

    localparam int DATA_W            = 16;
    localparam int IDX_W             = 8;
    localparam int PROD_W            = 2 * DATA_W;
    localparam int FRAC_W            = 15;
    localparam int INTERP_FACTOR_DEF = 4;
    localparam int SUB_TAPS_DEF      = 8;

    // Command codes carried by an input word
    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Saturation limits of a Q1.15 output
    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = -16'sh8000;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] sample_in;
        logic        [IDX_W-1:0]  coef_index;
        logic signed [DATA_W-1:0] coef_value;
    } pif_in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_out;
        logic                     clipped;
        logic                     last;
    } pif_out_word_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic idle;       // input side open
        logic issue;      // start one multiply-accumulate term
        logic term_first; // term opens a new sum
        logic term_last;  // term closes the sum
        logic emit;       // load the output register from the sum
        logic emit_last;  // emitted word is the final phase
    } pif_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sample_taken; // sample word accepted this cycle
        logic acc_done;     // sum complete and not yet emitted
        logic out_free;     // output register can take a word
    } pif_sts_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } pif_state_t;

endpackage

// File: src/pif_in_if.sv
// Input channel: valid/ready handshake carrying one input word
interface pif_in_if import pif_pkg::*; ();
    logic         valid;
    logic         ready;
    pif_in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/pif_out_if.sv
// Output channel: valid/ready handshake carrying one result word
interface pif_out_if import pif_pkg::*; ();
    logic          valid;
    logic          ready;
    pif_out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/pif_ram.sv
// Generic single-write, single-read RAM with registered read data
module pif_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: src/pif_datapath.sv
// Datapath: delay line, coefficient store, multiply-accumulate and output register
module pif_datapath import pif_pkg::*; #(
    parameter int INTERP_FACTOR = INTERP_FACTOR_DEF,
    parameter int SUB_TAPS      = SUB_TAPS_DEF,
    localparam int COEF_DEPTH   = INTERP_FACTOR * SUB_TAPS,
    localparam int AW           = $clog2(COEF_DEPTH),
    localparam int JW           = (SUB_TAPS > 1) ? $clog2(SUB_TAPS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    pif_in_if.sink           din,
    pif_out_if.source        dout,
    input  pif_cmd_t         cmd,
    input  logic [AW-1:0]    rd_addr,
    input  logic [JW-1:0]    tap_idx,
    output pif_sts_t         sts
);

    localparam int ACC_W = PROD_W + $clog2(SUB_TAPS) + 1;
    localparam int RND_W = ACC_W + 1;
    localparam int SHR_W = RND_W - FRAC_W;

    logic                     coef_wr;
    logic                     sample_wr;
    logic [COEF_DEPTH-1:0]    cvld_reg;
    logic [COEF_DEPTH-1:0]    cvld_next;
    logic [DATA_W-1:0]        ram_rdata;

    logic signed [DATA_W-1:0] taps_reg  [SUB_TAPS];
    logic signed [DATA_W-1:0] taps_next [SUB_TAPS];

    logic                     s1_vld_reg;
    logic                     s1_first_reg;
    logic                     s1_last_reg;
    logic                     s1_cvld_reg;
    logic signed [DATA_W-1:0] s1_tap_reg;
    logic signed [DATA_W-1:0] s1_coef;

    logic                     s2_vld_reg;
    logic                     s2_first_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    logic                     done_next;

    logic signed [RND_W-1:0]  rnd_sum;
    logic signed [SHR_W-1:0]  rnd_q;
    logic signed [DATA_W-1:0] sat_val;
    logic                     sat_clip;

    logic                     out_vld_reg;
    logic                     out_vld_next;
    pif_out_word_t            out_word_reg;
    pif_out_word_t            out_word_next;

    // Decode the accepted input word
    assign din.ready = cmd.idle;
    assign sample_wr = din.valid && cmd.idle && (din.data.command == CMD_SAMPLE);
    assign coef_wr   = din.valid && cmd.idle && (din.data.command == CMD_COEF) &&
                       ({1'b0, din.data.coef_index} < (IDX_W + 1)'(COEF_DEPTH));

    // Coefficient store
    pif_ram #(
        .WIDTH (DATA_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_wr),
        .waddr (din.data.coef_index[AW-1:0]),
        .wdata (din.data.coef_value),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Mark entries written since reset; unwritten entries read as zero
    always_comb
    begin
        cvld_next = cvld_reg;
        if (coef_wr)
        begin
            cvld_next[din.data.coef_index[AW-1:0]] = 1'b1;
        end
    end

    // Shift the new sample in at the top of the delay line
    always_comb
    begin
        taps_next = taps_reg;
        if (sample_wr)
        begin
            for (int i = 0; i < SUB_TAPS - 1; i++)
            begin
                taps_next[i] = taps_reg[i + 1];
            end
            taps_next[SUB_TAPS - 1] = din.data.sample_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvld_reg <= '0;
            for (int i = 0; i < SUB_TAPS; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else
        begin
            cvld_reg <= cvld_next;
            taps_reg <= taps_next;
        end
    end

    // Stage 1: coefficient read and tap select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.term_first;
        s1_last_reg  <= cmd.term_last;
        s1_cvld_reg  <= cvld_reg[rd_addr];
        s1_tap_reg   <= taps_reg[tap_idx];
    end

    assign s1_coef = s1_cvld_reg ? $signed(ram_rdata) : '0;

    // Stage 2: product
    assign prod_next = s1_coef * s1_tap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        prod_reg     <= prod_next;
    end

    // Stage 3: accumulate, flag the sum once its last term is in
    always_comb
    begin
        acc_next  = acc_reg;
        done_next = done_reg;
        if (s2_vld_reg)
        begin
            acc_next = (s2_first_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
        end
        if (cmd.emit)
        begin
            done_next = 1'b0;
        end
        else if (s2_vld_reg && s2_last_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Round half up to Q1.15 and saturate
    assign rnd_sum = RND_W'(acc_reg) + RND_W'(1 << (FRAC_W - 1));
    assign rnd_q   = SHR_W'(rnd_sum >>> FRAC_W);

    always_comb
    begin
        priority if (rnd_q > SHR_W'(SAT_MAX))
        begin
            sat_val  = SAT_MAX;
            sat_clip = 1'b1;
        end
        else if (rnd_q < SHR_W'(SAT_MIN))
        begin
            sat_val  = SAT_MIN;
            sat_clip = 1'b1;
        end
        else
        begin
            sat_val  = rnd_q[DATA_W-1:0];
            sat_clip = 1'b0;
        end
    end

    // Output register: load on emit, drop once taken
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_word_next = out_word_reg;
        if (cmd.emit)
        begin
            out_vld_next             = 1'b1;
            out_word_next.sample_out = sat_val;
            out_word_next.clipped    = sat_clip;
            out_word_next.last       = cmd.emit_last;
        end
        else if (dout.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign dout.valid = out_vld_reg;
    assign dout.data  = out_word_reg;

    // Status back to the controller
    assign sts.sample_taken = sample_wr;
    assign sts.acc_done     = done_reg;
    assign sts.out_free     = !out_vld_reg || dout.ready;

endmodule

// File: src/pif_ctrl.sv
// Controller: sequences phases and sub-tap terms of one sample word
module pif_ctrl import pif_pkg::*; #(
    parameter int INTERP_FACTOR = INTERP_FACTOR_DEF,
    parameter int SUB_TAPS      = SUB_TAPS_DEF,
    localparam int COEF_DEPTH   = INTERP_FACTOR * SUB_TAPS,
    localparam int AW           = $clog2(COEF_DEPTH),
    localparam int JW           = (SUB_TAPS > 1) ? $clog2(SUB_TAPS) : 1,
    localparam int PW           = $clog2(INTERP_FACTOR)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  pif_sts_t      sts,
    output pif_cmd_t      cmd,
    output logic [AW-1:0] rd_addr,
    output logic [JW-1:0] tap_idx
);

    pif_state_t    state_reg;
    pif_state_t    state_next;
    logic [PW-1:0] phase_reg;
    logic [PW-1:0] phase_next;
    logic [JW-1:0] tap_reg;
    logic [JW-1:0] tap_next;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;
    logic          tap_end;

    assign tap_end = (tap_reg == JW'(SUB_TAPS - 1));

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        tap_next   = tap_reg;
        addr_next  = addr_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.sample_taken)
                begin
                    phase_next = PW'(INTERP_FACTOR - 1);
                    addr_next  = AW'(INTERP_FACTOR - 1);
                    tap_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue      = 1'b1;
                cmd.term_first = (tap_reg == '0);
                cmd.term_last  = tap_end;
                if (tap_end)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    tap_next  = tap_reg + JW'(1);
                    addr_next = addr_reg + AW'(INTERP_FACTOR);
                end
            end
            ST_WAIT:
            begin
                cmd.emit_last = (phase_reg == '0);
                if (sts.acc_done && sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (phase_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_reg - PW'(1);
                        addr_next  = AW'(phase_reg - PW'(1));
                        tap_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            tap_reg   <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            tap_reg   <= tap_next;
            addr_reg  <= addr_next;
        end
    end

    assign rd_addr = addr_reg;
    assign tap_idx = tap_reg;

endmodule

// File: src/polyphase_interpolation_fir.sv
// Polyphase FIR interpolator by INTERP_FACTOR with SUB_TAPS taps per phase, Q1.15 in and out.
// A coefficient word (command 0) writes one entry of the INTERP_FACTOR*SUB_TAPS table and gives
// no result; indexes beyond the table are ignored. A sample word (command 1) shifts into the
// delay line and gives INTERP_FACTOR results, highest phase first, the last one flagged. Each
// result is the exact sum of SUB_TAPS products, rounded half up to Q1.15 and saturated, with
// clipped set when saturation applied. All terms go through one shared multiply-accumulate
// unit fed by a coefficient RAM with registered read, one product a cycle while a phase is
// being summed; each phase passes through the read, multiply and accumulate stages. The next
// word is accepted once the final result has been loaded into the output register, even if
// it has not yet been taken. Reset clears the delay line and makes the whole table read as
// zero.
module polyphase_interpolation_fir import pif_pkg::*; #(
    parameter int INTERP_FACTOR = INTERP_FACTOR_DEF,
    parameter int SUB_TAPS      = SUB_TAPS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pif_in_if.sink    din,
    pif_out_if.source dout
);

    localparam int COEF_DEPTH = INTERP_FACTOR * SUB_TAPS;
    localparam int AW         = $clog2(COEF_DEPTH);
    localparam int JW         = (SUB_TAPS > 1) ? $clog2(SUB_TAPS) : 1;

    pif_cmd_t      cmd;
    pif_sts_t      sts;
    logic [AW-1:0] rd_addr;
    logic [JW-1:0] tap_idx;

    pif_ctrl #(
        .INTERP_FACTOR (INTERP_FACTOR),
        .SUB_TAPS      (SUB_TAPS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .sts     (sts),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .tap_idx (tap_idx)
    );

    pif_datapath #(
        .INTERP_FACTOR (INTERP_FACTOR),
        .SUB_TAPS      (SUB_TAPS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din),
        .dout    (dout),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .tap_idx (tap_idx),
        .sts     (sts)
    );

endmodule

// File: src/pif_checker.sv
// Port-level checker for the polyphase interpolator, bound to the top level
`include "polyphase_interpolation_fir_macros.svh"

module pif_checker import pif_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    input logic          din_valid,
    input logic          din_ready,
    input pif_in_word_t  din_data,
    input logic          dout_valid,
    input logic          dout_ready,
    input pif_out_word_t dout_data
);

    // A stalled result word holds
    `PIF_ASSERT_NEXT(a_out_hold, clk, rst_n, dout_valid && !dout_ready, dout_valid && $stable(dout_data), "result word changed while stalled")

    // A sample word closes the input until its results are out
    `PIF_ASSERT_NEXT(a_sample_blocks, clk, rst_n, din_valid && din_ready && (din_data.command == CMD_SAMPLE), !din_ready, "input stayed open after a sample word")

    // The input reopens only together with the final result of a sample
    `PIF_ASSERT_SAME(a_reopen_last, clk, rst_n, $rose(din_ready), dout_valid && dout_data.last, "input reopened without a final result")

    // A non-final result only shows while the input is closed
    `PIF_ASSERT_SAME(a_mid_closed, clk, rst_n, dout_valid && !dout_data.last, !din_ready, "input open while a phase result is pending")

endmodule

bind polyphase_interpolation_fir pif_checker u_pif_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .din_valid  (din.valid),
    .din_ready  (din.ready),
    .din_data   (din.data),
    .dout_valid (dout.valid),
    .dout_ready (dout.ready),
    .dout_data  (dout.data)
);
